// ===== src/rfw_pkg.sv =====
// Shared types and constants for the RGB fade and wait engine.
// No dependencies; imported by rgb_fade_wait_engine.
`default_nettype none

package rfw_pkg;

  // Width of one color channel and number of channels.
  localparam int unsigned ChanBits = 8;
  localparam int unsigned NumChan  = 3;

  // Default width of the time counters (fade length, elapsed, wait).
  localparam int unsigned TimeBitsDef = 16;

  // Width of the duration field on the input stream.
  localparam int unsigned DurBits = 16;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_SET  = 2'd1,
    MODE_FADE = 2'd2,
    MODE_WAIT = 2'd3
  } mode_e;

endpackage

`default_nettype wire

// ===== src/rgb_fade_wait_engine.sv =====
// Top level of the RGB fade and wait engine: state, sequencer and bit-serial interpolator.
// Depends on rfw_pkg for channel widths and request kinds.
// A tick that interpolates runs, for each of the three channels, a load step, the multiply steps
// and the divide steps, then the output load, which waits while the output register is full.
// Every other request goes straight to the output load. One request is in work at a time,
// so a new request is taken only after the last result has been loaded into the output register.
// Reset (rst_ni low, asynchronous) clears colors, timers, the sequencer and the output register.
`default_nettype none

module rgb_fade_wait_engine
  import rfw_pkg::*;
#(
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [7:0] red_in, [15:8] green_in, [23:16] blue_in, [39:24] duration
  input  wire logic [39:0] s_axis_tdata_i,
  // [1:0] mode
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [24] busy_res, [25] rejected
  output logic [31:0]      m_axis_tdata_o
);

  localparam int unsigned AccBits = TIME_BITS + ChanBits;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e                 state_q;
  logic [ChanBits-1:0]    colour_q [NumChan];
  logic [ChanBits-1:0]    start_q  [NumChan];
  logic [ChanBits-1:0]    target_q [NumChan];
  logic [TIME_BITS-1:0]   len_q;
  logic [TIME_BITS-1:0]   elapsed_q;
  logic [TIME_BITS-1:0]   wait_q;
  logic                   fading_q;
  logic                   waiting_q;
  logic                   rej_q;
  logic [1:0]             ch_q;
  logic [2:0]             cnt_q;
  logic [ChanBits-1:0]    diff_q;
  logic                   up_q;
  logic [AccBits-1:0]     acc_q;
  logic                   m_tvalid_q;
  logic [31:0]            m_tdata_q;

  // Request fields.
  mode_e                  mode;
  logic [ChanBits-1:0]    rgb_in [NumChan];
  logic [DurBits-1:0]     dur_in;
  logic [31:0]            dur_ext;
  logic [TIME_BITS-1:0]   dur_sat;
  logic                   in_fire;
  logic                   busy;
  logic                   out_free;

  assign mode      = mode_e'(s_axis_tuser_i);
  assign rgb_in[0] = s_axis_tdata_i[7:0];
  assign rgb_in[1] = s_axis_tdata_i[15:8];
  assign rgb_in[2] = s_axis_tdata_i[23:16];
  assign dur_in    = s_axis_tdata_i[39:24];

  // Saturate the duration to what the time counters can hold.
  assign dur_ext = 32'(dur_in);
  assign dur_sat = ((dur_ext >> TIME_BITS) != 32'd0) ? '1 : TIME_BITS'(dur_in);

  assign busy            = fading_q | waiting_q;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~m_tvalid_q | m_axis_tready_i;
  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

  // Timer updates for a tick.
  logic [TIME_BITS-1:0] wait_dec;
  logic [TIME_BITS-1:0] elapsed_inc;

  assign wait_dec    = (wait_q != '0) ? wait_q - 1'b1 : wait_q;
  assign elapsed_inc = (elapsed_q < len_q) ? elapsed_q + 1'b1 : elapsed_q;

  // Channel difference magnitude and direction for the channel in work.
  logic [ChanBits-1:0] chan_s;
  logic [ChanBits-1:0] chan_t;
  logic                chan_up;
  logic [ChanBits-1:0] chan_diff;

  assign chan_s    = start_q[ch_q];
  assign chan_t    = target_q[ch_q];
  assign chan_up   = (chan_t >= chan_s);
  assign chan_diff = chan_up ? chan_t - chan_s : chan_s - chan_t;

  // Multiply step: one bit of the difference per cycle, MSB first.
  logic [AccBits-1:0] mul_d;

  assign mul_d = (acc_q << 1) + (diff_q[ChanBits-1] ? AccBits'(elapsed_q) : '0);

  // Divide step: restoring division, one quotient bit per cycle shifted into the low byte.
  logic [TIME_BITS:0]   trial;
  logic                 qbit;
  logic [TIME_BITS:0]   trial_sub;
  logic [AccBits-1:0]   div_d;
  logic [ChanBits-1:0]  lerp;

  assign trial     = acc_q[AccBits-1:ChanBits-1];
  assign qbit      = (trial >= {1'b0, len_q});
  assign trial_sub = trial - {1'b0, len_q};
  assign div_d     = {qbit ? trial_sub[TIME_BITS-1:0] : trial[TIME_BITS-1:0],
                      acc_q[ChanBits-2:0], qbit};
  assign lerp      = up_q ? start_q[ch_q] + div_d[ChanBits-1:0]
                          : start_q[ch_q] - div_d[ChanBits-1:0];

  // Sequencer, engine state and registered output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      for (int k = 0; k < NumChan; k++) begin
        colour_q[k] <= '0;
        start_q[k]  <= '0;
        target_q[k] <= '0;
      end
      len_q      <= '0;
      elapsed_q  <= '0;
      wait_q     <= '0;
      fading_q   <= 1'b0;
      waiting_q  <= 1'b0;
      rej_q      <= 1'b0;
      ch_q       <= '0;
      cnt_q      <= '0;
      diff_q     <= '0;
      up_q       <= 1'b0;
      acc_q      <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
    end else begin
      // The output register empties when taken, unless a new result loads it now.
      if (m_tvalid_q && m_axis_tready_i && (state_q != ST_DONE)) begin
        m_tvalid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            rej_q   <= 1'b0;
            state_q <= ST_DONE;
            if (mode == MODE_TICK) begin
              if (waiting_q) begin
                wait_q    <= wait_dec;
                waiting_q <= (wait_dec != '0);
              end else if (fading_q) begin
                elapsed_q <= elapsed_inc;
                if (elapsed_inc >= len_q) begin
                  for (int k = 0; k < NumChan; k++) begin
                    colour_q[k] <= target_q[k];
                  end
                  fading_q <= 1'b0;
                end else begin
                  ch_q    <= '0;
                  state_q <= ST_LOAD;
                end
              end
            end else if (busy) begin
              rej_q <= 1'b1;
            end else begin
              unique case (mode)
                MODE_SET: begin
                  for (int k = 0; k < NumChan; k++) begin
                    colour_q[k] <= rgb_in[k];
                  end
                end
                MODE_FADE: begin
                  if (dur_sat == '0) begin
                    for (int k = 0; k < NumChan; k++) begin
                      colour_q[k] <= rgb_in[k];
                    end
                  end else begin
                    for (int k = 0; k < NumChan; k++) begin
                      start_q[k]  <= colour_q[k];
                      target_q[k] <= rgb_in[k];
                    end
                    len_q     <= dur_sat;
                    elapsed_q <= '0;
                    fading_q  <= 1'b1;
                  end
                end
                MODE_WAIT: begin
                  wait_q    <= dur_sat;
                  waiting_q <= (dur_sat != '0);
                end
                default: begin
                end
              endcase
            end
          end
        end

        ST_LOAD: begin
          diff_q  <= chan_diff;
          up_q    <= chan_up;
          acc_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_MUL;
        end

        ST_MUL: begin
          acc_q  <= mul_d;
          diff_q <= {diff_q[ChanBits-2:0], 1'b0};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == 3'd7) begin
            state_q <= ST_DIV;
          end
        end

        ST_DIV: begin
          acc_q <= div_d;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 3'd7) begin
            colour_q[ch_q] <= lerp;
            if (ch_q == 2'(NumChan - 1)) begin
              state_q <= ST_DONE;
            end else begin
              ch_q    <= ch_q + 1'b1;
              state_q <= ST_LOAD;
            end
          end
        end

        ST_DONE: begin
          if (out_free) begin
            m_tvalid_q <= 1'b1;
            m_tdata_q  <= {6'd0, rej_q, busy, colour_q[2], colour_q[1], colour_q[0]};
            state_q    <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/rgb_fade_wait_engine_test.sv =====
// Self-checking test of rgb_fade_wait_engine: directed table, then random light sequences.
// Depends on rfw_pkg (mode_e, widths) and the rgb_fade_wait_engine RTL.
`default_nettype none

module rgb_fade_wait_engine_test;
  import rfw_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned RandomGoal = 850;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned HoldAt = 520;
  localparam int unsigned IdlePct = 34;
  localparam int unsigned NumRows = 25;

  // One result as it appears on the output stream.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       busy;
    logic       rejected;
  } led_out_t;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    mode_e       mode;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] dur;
    logic        typed;
    led_out_t    want;
  } stim_row_t;

  localparam stim_row_t DirRows [NumRows] = '{
    // Tick straight after reset: all dark and idle.
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
    // Set color at both extremes of every channel.
    '{MODE_SET,  8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0}},
    '{MODE_SET,  8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
    '{MODE_SET,  8'hAA, 8'h55, 8'h0F, 16'h0000, 1'b1, '{8'hAA, 8'h55, 8'h0F, 1'b0, 1'b0}},
    // Zero-length fade jumps to the target; zero-length wait never goes busy.
    '{MODE_FADE, 8'h12, 8'h34, 8'h56, 16'h0000, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b0, 1'b0}},
    '{MODE_WAIT, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b0, 1'b0}},
    // Two-tick wait, with every command kind rejected while it runs.
    '{MODE_WAIT, 8'h00, 8'h00, 8'h00, 16'h0002, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b1, 1'b0}},
    '{MODE_SET,  8'hFF, 8'h00, 8'hFF, 16'h0000, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b1, 1'b1}},
    '{MODE_FADE, 8'h00, 8'hFF, 8'h00, 16'h0005, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b1, 1'b1}},
    '{MODE_WAIT, 8'h00, 8'h00, 8'h00, 16'hFFFF, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b1, 1'b1}},
    '{MODE_TICK, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b1, 1'b0}},
    // The tick that ends the wait, then a tick while idle.
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b0, 1'b0}},
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b0, 1'b0}},
    // Four-tick fade with channels moving both ways.
    '{MODE_FADE, 8'hFF, 8'h00, 8'h80, 16'h0004, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b1, 1'b0}},
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, '0},
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, '0},
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, '0},
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, '{8'hFF, 8'h00, 8'h80, 1'b0, 1'b0}},
    // Three-tick fade with a rejected set before its first tick.
    '{MODE_FADE, 8'h00, 8'hFF, 8'h00, 16'h0003, 1'b0, '0},
    '{MODE_SET,  8'h11, 8'h22, 8'h33, 16'h0000, 1'b0, '0},
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, '0},
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, '0},
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, '{8'h00, 8'hFF, 8'h00, 1'b0, 1'b0}},
    // One-tick wait.
    '{MODE_WAIT, 8'h00, 8'h00, 8'h00, 16'h0001, 1'b1, '{8'h00, 8'hFF, 8'h00, 1'b1, 1'b0}},
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, '{8'h00, 8'hFF, 8'h00, 1'b0, 1'b0}}
  };

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // [7:0] red_in, [15:8] green_in, [23:16] blue_in, [39:24] duration
  logic [39:0] s_axis_tdata_i = '0;
  // [1:0] mode
  logic [1:0]  s_axis_tuser_i = MODE_TICK;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [24] busy_res, [25] rejected
  logic [31:0] m_axis_tdata_o;

  // Predicted light state.
  logic [7:0]  lit_rgb [3];
  logic [7:0]  fade_from [3];
  logic [7:0]  fade_to [3];
  logic [15:0] fade_len;
  logic [15:0] fade_elapsed;
  logic        lit_fading;
  logic [15:0] wait_left;
  logic        lit_waiting;

  led_out_t    pending_led_q [$];
  int unsigned accepted_cnt = 0;
  int unsigned results_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned fades_run = 0;
  int unsigned waits_run = 0;
  int unsigned rejects_run = 0;
  int unsigned cycle_cnt = 0;
  bit          hold_done = 1'b0;

  rgb_fade_wait_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // A window of accepted requests in which neither side idles.
  function automatic bit calm_window();
    return accepted_cnt >= 120 && accepted_cnt < 260;
  endfunction

  // Linear blend of one channel, truncated toward the start value.
  function automatic logic [7:0] blend(logic [7:0] s, logic [7:0] t, logic [15:0] e,
                                       logic [15:0] len);
    int unsigned span;
    int unsigned step;
    if (len == 0) return t;
    span = (t >= s) ? t - s : s - t;
    step = (span * e) / len;
    return (t >= s) ? s + step[7:0] : s - step[7:0];
  endfunction

  // Advances the predicted state by one request and returns the result it gives.
  function automatic led_out_t step_led(mode_e mode, logic [7:0] r, logic [7:0] g,
                                        logic [7:0] b, logic [15:0] dur);
    logic [7:0] rgb [3];
    led_out_t   res;
    logic       was_busy;
    rgb[0] = r;
    rgb[1] = g;
    rgb[2] = b;
    was_busy = lit_fading || lit_waiting;
    res.rejected = 1'b0;
    if (mode == MODE_TICK) begin
      // A wait counts down first; otherwise a fade moves on by one step.
      if (lit_waiting) begin
        if (wait_left != 0) wait_left--;
        if (wait_left == 0) lit_waiting = 1'b0;
      end else if (lit_fading) begin
        if (fade_elapsed < fade_len) fade_elapsed++;
        for (int k = 0; k < 3; k++) begin
          lit_rgb[k] = (fade_elapsed >= fade_len) ? fade_to[k] :
                       blend(fade_from[k], fade_to[k], fade_elapsed, fade_len);
        end
        if (fade_elapsed >= fade_len) lit_fading = 1'b0;
      end
    end else if (was_busy) begin
      res.rejected = 1'b1;
      rejects_run++;
    end else begin
      case (mode)
        MODE_SET: begin
          for (int k = 0; k < 3; k++) lit_rgb[k] = rgb[k];
        end
        MODE_FADE: begin
          if (dur == 0) begin
            for (int k = 0; k < 3; k++) lit_rgb[k] = rgb[k];
          end else begin
            for (int k = 0; k < 3; k++) begin
              fade_from[k] = lit_rgb[k];
              fade_to[k] = rgb[k];
            end
            fade_len = dur;
            fade_elapsed = '0;
            lit_fading = 1'b1;
            fades_run++;
          end
        end
        default: begin
          wait_left = dur;
          lit_waiting = (dur != 0);
          if (dur != 0) waits_run++;
        end
      endcase
    end
    res.red = lit_rgb[0];
    res.green = lit_rgb[1];
    res.blue = lit_rgb[2];
    res.busy = lit_fading || lit_waiting;
    return res;
  endfunction

  // Offers one request, waits for it to be taken and queues its predicted result.
  task automatic push_request(input mode_e mode, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [15:0] dur,
                              input logic typed = 1'b0, input led_out_t want = '0);
    led_out_t res;
    while (!calm_window() && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {dur, b, g, r};
    s_axis_tuser_i <= mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    res = step_led(mode, r, g, b, dur);
    pending_led_q.push_back(typed ? want : res);
    accepted_cnt++;
  endtask

  // Duration for a command issued while idle: mostly short, now and then longer.
  function automatic logic [15:0] pick_span();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 75) return 16'($urandom_range(12, 1));
    if (roll < 98) return 16'($urandom_range(64, 13));
    return 16'($urandom_range(200, 65));
  endfunction

  // Prints one line per mismatch, up to a cap, and counts them all.
  task automatic note_mismatch(input string what, input led_out_t got, input led_out_t want);
    if (mismatch_cnt < 40) begin
      $display("mismatch at result %0d (%s): got r=%02h g=%02h b=%02h busy=%b rej=%b, want r=%02h g=%02h b=%02h busy=%b rej=%b",
               results_cnt, what, got.red, got.green, got.blue, got.busy, got.rejected,
               want.red, want.green, want.blue, want.busy, want.rejected);
    end
    mismatch_cnt++;
  endtask

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    led_out_t got;
    led_out_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.red = m_axis_tdata_o[7:0];
      got.green = m_axis_tdata_o[15:8];
      got.blue = m_axis_tdata_o[23:16];
      got.busy = m_axis_tdata_o[24];
      got.rejected = m_axis_tdata_o[25];
      if (pending_led_q.size() == 0) begin
        note_mismatch("nothing pending", got, '0);
      end else begin
        want = pending_led_q.pop_front();
        if (got !== want) note_mismatch("field", got, want);
      end
      results_cnt++;
    end
  end

  // Receiver pacing, with one long hold-off while requests keep coming.
  initial begin : sink_pacing
    int unsigned held;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!hold_done && accepted_cnt >= HoldAt) begin
        hold_done = 1'b1;
        m_axis_tready_i <= 1'b0;
        for (held = 0; held < HoldCycles; held++) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= calm_window() ? 1'b1 : ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("TB_ERROR");
    $finish;
  end

  // Main sequence: reset, directed table, random light sequences, long fade, drain.
  initial begin : main_flow
    int unsigned roll;
    for (int k = 0; k < 3; k++) begin
      lit_rgb[k] = '0;
      fade_from[k] = '0;
      fade_to[k] = '0;
    end
    fade_len = '0;
    fade_elapsed = '0;
    lit_fading = 1'b0;
    wait_left = '0;
    lit_waiting = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      push_request(DirRows[i].mode, DirRows[i].red, DirRows[i].green, DirRows[i].blue,
                   DirRows[i].dur, DirRows[i].typed, DirRows[i].want);
    end

    // Mostly well-formed: a command when idle, ticks until done, some noise on the way.
    while (accepted_cnt < RandomGoal) begin
      roll = $urandom_range(99);
      if (!(lit_fading || lit_waiting)) begin
        if (roll < 15) begin
          push_request(MODE_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
        end else if (roll < 30) begin
          push_request(MODE_SET, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
        end else if (roll < 75) begin
          push_request(MODE_FADE, 8'($urandom), 8'($urandom), 8'($urandom), pick_span());
        end else begin
          push_request(MODE_WAIT, 8'($urandom), 8'($urandom), 8'($urandom), pick_span());
        end
      end else if (roll < 10) begin
        push_request(mode_e'($urandom_range(3, 1)), 8'($urandom), 8'($urandom),
                     8'($urandom), 16'($urandom));
      end else begin
        push_request(MODE_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
      end
    end

    // Finish whatever runs, then a fade of the longest length with a few ticks into it.
    while (lit_fading || lit_waiting) begin
      push_request(MODE_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
    end
    push_request(MODE_FADE, 8'($urandom), 8'($urandom), 8'($urandom), 16'hFFFF);
    repeat (24) push_request(MODE_TICK, 8'h00, 8'h00, 8'h00, 16'h0000);

    s_axis_tvalid_i <= 1'b0;
    while (pending_led_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d requests: %0d fades, %0d waits, %0d rejected commands.",
             accepted_cnt, fades_run, waits_run, rejects_run);
    $display("Checked %0d results, one %0d-cycle output hold-off, %0d mismatches.",
             results_cnt, HoldCycles, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
